/* rtl/core/assert_macros.svh */
// assertion macros included by the checker file aaip_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds through reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/aaip_pkg.sv */
// types, constants and helper functions of the advertising interval policy
package aaip_pkg;

   localparam int TIME_BITS_DEFAULT = 48;

   localparam int PERIOD_W = 14;
   localparam int UNITS_W  = 15;
   localparam int QUIET_W  = 24;
   localparam int TMO_W    = 34;
   localparam int ACCEL_W  = 16;
   localparam int TEMP_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [PERIOD_W-1:0] SAFE_PERIOD = 14'd10000;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN  = 14'd100;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 14'd10240;
   localparam logic [UNITS_W-1:0]  UNITS_MAX   = 15'h4000;
   localparam logic [TMO_W-1:0]    US_PER_MS   = 34'd1000;

   // register reset values
   localparam logic                 SAFE_MODE_RST  = 1'b0;
   localparam logic                 ADAPTIVE_RST   = 1'b1;
   localparam logic [PERIOD_W-1:0]  MOVING_RST     = 14'd1000;
   localparam logic [PERIOD_W-1:0]  STATIONARY_RST = 14'd3000;
   localparam logic [TMO_W-1:0]     QUIET_US_RST   = 34'd300000000;
   localparam logic [ACCEL_W-1:0]   MOTION_THR_RST = 16'd25;
   localparam logic [TEMP_W-1:0]    TEMP_STEP_RST  = 16'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAFE_MODE      = 3'd0,
      CSR_ADAPTIVE       = 3'd1,
      CSR_MOVING_PERIOD  = 3'd2,
      CSR_STAT_PERIOD    = 3'd3,
      CSR_QUIET_TIMEOUT  = 3'd4,
      CSR_MOTION_THR     = 3'd5,
      CSR_TEMP_STEP      = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_SAFE       = 2'd0,
      ST_FIXED      = 2'd1,
      ST_MOVING     = 2'd2,
      ST_STATIONARY = 2'd3
   } policy_state_type;

   typedef enum logic {
      MODE_START  = 1'b0,
      MODE_SAMPLE = 1'b1
   } req_mode_type;

   function automatic logic [PERIOD_W-1:0] moving_eff(input logic [PERIOD_W-1:0] mov);
      logic [PERIOD_W-1:0] m;
      m = mov;
      if (m < PERIOD_MIN) m = PERIOD_MIN;
      if (m > PERIOD_MAX) m = PERIOD_MAX;
      return m;
   endfunction

   function automatic logic [PERIOD_W-1:0] period_of(input policy_state_type st,
                                                     input logic [PERIOD_W-1:0] mov,
                                                     input logic [PERIOD_W-1:0] sta);
      logic [PERIOD_W-1:0] m;
      logic [PERIOD_W-1:0] s;
      m = moving_eff(mov);
      s = sta;
      if (s < m) s = m;
      if (s > PERIOD_MAX) s = PERIOD_MAX;
      case (st)
         ST_SAFE:       return SAFE_PERIOD;
         ST_STATIONARY: return s;
         default:       return m;
      endcase
   endfunction

   // period * 8 / 5 by reciprocal multiply, exact for 17-bit numerators
   function automatic logic [UNITS_W-1:0] units_of(input logic [PERIOD_W-1:0] p);
      logic [16:0] n;
      logic [32:0] prod;
      logic [UNITS_W-1:0] q;
      n = {p, 3'b000};
      prod = 33'(n) * 33'd52429;
      q = prod[32:18];
      return (q > UNITS_MAX) ? UNITS_MAX : q;
   endfunction

endpackage

/* rtl/core/adaptive_advert_interval_policy_unit.sv */
// advertising interval policy: activity state machine with registered result word
//
//  channel | ports                          | direction | handshake
//  --------+--------------------------------+-----------+-----------------
//  req     | req_mode, req_now_us, temps... | in        | req_valid / req_stall
//  rsp     | rsp_policy_state ... changed   | out       | rsp_valid / rsp_stall
//  csr     | csr_index, csr_wdata           | in        | csr_wr_en
//
// one word per cycle while req_stall is low; each result is registered and appears in the cycle after its request word
// the whole update is one pass of compare logic into the state and result registers
// req_stall is high only while a result waits and rsp_stall holds it
// synchronous active-high reset: state moving, period 1000 ms, registers to defaults
// quiet timeout is held in microseconds, multiplied by 1000 when written
module adaptive_advert_interval_policy_unit
   import aaip_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [TIME_BITS-1:0]  req_now_us,
   input  logic [ACCEL_W-1:0]    req_accel_rms_mg,
   input  logic signed [TEMP_W-1:0] req_temp_a_x100,
   input  logic signed [TEMP_W-1:0] req_temp_b_x100,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_policy_state,
   output logic [PERIOD_W-1:0]   rsp_period_ms,
   output logic [UNITS_W-1:0]    rsp_period_units,
   output logic                  rsp_period_changed,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CMP_W = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;

   // configuration registers
   logic                safe_mode_ff;
   logic                adaptive_ff;
   logic [PERIOD_W-1:0] moving_ff;
   logic [PERIOD_W-1:0] stationary_ff;
   logic [TMO_W-1:0]    quiet_us_ff;
   logic [ACCEL_W-1:0]  motion_thr_ff;
   logic [TEMP_W-1:0]   temp_step_ff;

   // policy state
   policy_state_type       state_ff, state_in;
   logic [PERIOD_W-1:0]    period_ff, period_in;
   logic [TIME_BITS-1:0]   last_ff, last_in;
   logic signed [TEMP_W-1:0] ref_a_ff, ref_a_in;
   logic signed [TEMP_W-1:0] ref_b_ff, ref_b_in;
   logic                   ref_valid_ff, ref_valid_in;
   logic                   changed_in;

   // result register
   logic                   rsp_valid_ff;
   policy_state_type       rsp_state_ff;
   logic [PERIOD_W-1:0]    rsp_period_ff;
   logic [UNITS_W-1:0]     rsp_units_ff;
   logic                   rsp_changed_ff;

   logic                   accept;
   logic                   motion;
   logic                   temp_wake;
   logic                   quiet_hit;
   logic [TIME_BITS-1:0]   elapsed;
   logic signed [TEMP_W:0] diff_a, diff_b;
   logic [TEMP_W:0]        mag_a, mag_b;
   logic                   go;
   policy_state_type       target;
   logic [PERIOD_W-1:0]    target_period;
   policy_state_type       start_state;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign motion  = req_accel_rms_mg >= motion_thr_ff;
   assign elapsed = req_now_us - last_ff;
   assign quiet_hit = CMP_W'(elapsed) >= CMP_W'(quiet_us_ff);

   assign diff_a = {req_temp_a_x100[TEMP_W-1], req_temp_a_x100} - {ref_a_ff[TEMP_W-1], ref_a_ff};
   assign diff_b = {req_temp_b_x100[TEMP_W-1], req_temp_b_x100} - {ref_b_ff[TEMP_W-1], ref_b_ff};
   assign mag_a  = diff_a[TEMP_W] ? (TEMP_W+1)'(-diff_a) : (TEMP_W+1)'(diff_a);
   assign mag_b  = diff_b[TEMP_W] ? (TEMP_W+1)'(-diff_b) : (TEMP_W+1)'(diff_b);
   assign temp_wake = ref_valid_ff &&
                      (mag_a >= (TEMP_W+1)'(temp_step_ff) || mag_b >= (TEMP_W+1)'(temp_step_ff));

   assign start_state = safe_mode_ff ? ST_SAFE : (adaptive_ff ? ST_MOVING : ST_FIXED);
   assign target_period = period_of(target, moving_ff, stationary_ff);

   always_comb begin
      state_in     = state_ff;
      period_in    = period_ff;
      last_in      = last_ff;
      ref_a_in     = ref_a_ff;
      ref_b_in     = ref_b_ff;
      ref_valid_in = ref_valid_ff;
      changed_in   = 1'b0;
      go           = 1'b0;
      target       = ST_MOVING;
      if (req_mode == MODE_START) begin
         target = start_state;
      end else if (state_ff == ST_MOVING) begin
         target = ST_STATIONARY;
      end
      if (accept) begin
         if (req_mode == MODE_START) begin
            state_in     = start_state;
            period_in    = target_period;
            last_in      = req_now_us;
            ref_valid_in = 1'b0;
         end else if (state_ff == ST_MOVING) begin
            ref_a_in     = req_temp_a_x100;
            ref_b_in     = req_temp_b_x100;
            ref_valid_in = 1'b1;
            if (motion) begin
               last_in = req_now_us;
            end else if (quiet_hit) begin
               go = 1'b1;
            end
         end else if (state_ff == ST_STATIONARY) begin
            if (motion || temp_wake) begin
               last_in = req_now_us;
               go      = 1'b1;
            end
         end
         if (go) begin
            state_in = target;
            if (target_period != period_ff) begin
               period_in  = target_period;
               changed_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         safe_mode_ff  <= SAFE_MODE_RST;
         adaptive_ff   <= ADAPTIVE_RST;
         moving_ff     <= MOVING_RST;
         stationary_ff <= STATIONARY_RST;
         quiet_us_ff   <= QUIET_US_RST;
         motion_thr_ff <= MOTION_THR_RST;
         temp_step_ff  <= TEMP_STEP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SAFE_MODE:     safe_mode_ff  <= csr_wdata[0];
            CSR_ADAPTIVE:      adaptive_ff   <= csr_wdata[0];
            CSR_MOVING_PERIOD: moving_ff     <= csr_wdata[PERIOD_W-1:0];
            CSR_STAT_PERIOD:   stationary_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_QUIET_TIMEOUT: quiet_us_ff   <= TMO_W'(csr_wdata[QUIET_W-1:0]) * US_PER_MS;
            CSR_MOTION_THR:    motion_thr_ff <= csr_wdata[ACCEL_W-1:0];
            CSR_TEMP_STEP:     temp_step_ff  <= csr_wdata[TEMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_MOVING;
         period_ff    <= MOVING_RST;
         last_ff      <= '0;
         ref_a_ff     <= '0;
         ref_b_ff     <= '0;
         ref_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         last_ff      <= last_in;
         ref_a_ff     <= ref_a_in;
         ref_b_ff     <= ref_b_in;
         ref_valid_ff <= ref_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_state_ff   <= state_in;
         rsp_period_ff  <= period_in;
         rsp_units_ff   <= units_of(period_in);
         rsp_changed_ff <= changed_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_policy_state   = rsp_state_ff;
   assign rsp_period_ms      = rsp_period_ff;
   assign rsp_period_units   = rsp_units_ff;
   assign rsp_period_changed = rsp_changed_ff;

endmodule

/* rtl/core/aaip_checker.sv */
// port-level checks of the advertising interval policy, bound to the top level
`include "assert_macros.svh"

module aaip_port_checker
   import aaip_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_mode,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_policy_state,
   input logic [PERIOD_W-1:0] rsp_period_ms,
   input logic [UNITS_W-1:0]  rsp_period_units,
   input logic                rsp_period_changed
);

   // a held result word keeps its period and state
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_period_ms) && $stable(rsp_policy_state),
      "result word changed while stalled")

   // the input side waits only behind a held result
   `ASSERT_CLK(a_stall_source, clock, reset,
      req_stall == (rsp_valid && rsp_stall),
      "req_stall not tied to a held result")

   // units follow the reported period whenever a result is valid
   `ASSERT_CLK(a_units_match, clock, reset,
      rsp_valid |-> rsp_period_units == units_of(rsp_period_ms),
      "period_units does not match period_ms")

   // start words never report a changed period
   `ASSERT_CLK(a_start_no_change, clock, reset,
      req_valid && !req_stall && req_mode == MODE_START |=> rsp_valid && !rsp_period_changed,
      "start word reported a period change")

   // safe and fixed states are entered only by start and never move
   `ASSERT_CLK(a_static_states, clock, reset,
      rsp_valid && (rsp_policy_state == ST_SAFE || rsp_policy_state == ST_FIXED)
         |-> !rsp_period_changed,
      "period change reported in safe or fixed state")

endmodule

bind adaptive_advert_interval_policy_unit aaip_port_checker u_aaip_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_mode           (req_mode),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_policy_state   (rsp_policy_state),
   .rsp_period_ms      (rsp_period_ms),
   .rsp_period_units   (rsp_period_units),
   .rsp_period_changed (rsp_period_changed)
);
